[rtl/core/box_blur_three_by_three_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 box blur checker
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_THREE_BY_THREE_TOP_ASSERT_SVH
`define BOX_BLUR_THREE_BY_THREE_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define BBL_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define BBL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also runs through reset
`define BBL_ASSERT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/bbl_pkg.sv]
// ----------------------------------------------------------------------------
// bbl_pkg
// Shared constants and types for the 3x3 box blur.
// ----------------------------------------------------------------------------
package bbl_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = 11;
  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  // wide enough for frame_width, MAX_WIDTH and column + 1
  localparam int CMP_W     = ((FW_W > COL_W + 1) ? FW_W : COL_W + 1) + 1;

  localparam int PIX_W     = 8;
  localparam int RGB_W     = 3 * PIX_W;
  localparam int CSUM_W    = 10;   // three pixels of one channel
  localparam int SUM_W     = 12;   // nine pixels of one channel
  localparam int DIV_W     = 4;

  localparam int Q_DEPTH   = 4;
  localparam int QA_W      = $clog2(Q_DEPTH);
  localparam int QC_W      = $clog2(Q_DEPTH + 1);

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam logic [ADDR_W-3:0] REG_FRAME_WIDTH = 1'b0;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } bbl_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             run_last;
    logic             frame_end;
  } bbl_out_t;

  // one classified item: vertical column sums (2 red, 1 green, 0 blue) and flags
  typedef struct packed {
    logic [2:0][CSUM_W-1:0] col;
    logic [1:0]             vcnt;
    logic                   c_ge1;
    logic                   c_ge2;
    logic                   last;
    logic                   kind;
    logic                   rs1;
  } bbl_entry_t;

  typedef struct packed {
    logic            empty;
    logic [QC_W-1:0] count;
  } bbl_qstat_t;

endpackage

[rtl/core/bbl_queue.sv]
// ----------------------------------------------------------------------------
// bbl_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module bbl_queue
  import bbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bbl_entry_t push_data,
  input  logic       pop,
  output bbl_entry_t pop_data,
  output bbl_qstat_t stat
);

  bbl_entry_t      slot_r [Q_DEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QA_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QA_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = slot_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule

[rtl/core/bbl_front.sv]
// ----------------------------------------------------------------------------
// bbl_front
// Accepts pixels, tracks column and row, reads the two line stores and
// builds the vertical column sums for the back.
// ----------------------------------------------------------------------------
module bbl_front
  import bbl_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  bbl_in_t         in_data,
  input  logic [FW_W-1:0] frame_width,
  input  bbl_qstat_t      qstat,
  output logic            push,
  output bbl_entry_t      push_data
);

  // line store: older row in the upper half, newer row in the lower half
  logic [2*RGB_W-1:0] mem [MAX_WIDTH];

  logic [COL_W-1:0]   col_pos_r, col_pos_nxt;
  logic [1:0]         rows_r, rows_nxt;

  logic               s2_v_r;
  logic               s2_kind_r;
  logic [RGB_W-1:0]   s2_pix_r;
  logic [COL_W-1:0]   s2_c_r;
  logic               s2_last_r;
  logic [1:0]         s2_rows_r;
  logic [2*RGB_W-1:0] rd_data_r;
  logic               byp_v_r;
  logic [2*RGB_W-1:0] byp_data_r;

  logic               accept;
  logic [CMP_W-1:0]   fw_ext, w_eff, c_inc;
  logic               last;
  logic [2*RGB_W-1:0] rows_word, wr_data;
  logic [RGB_W-1:0]   top, centre;

  assign in_stall = ((QC_W+1)'(qstat.count) + (QC_W+1)'(s2_v_r)) >= (QC_W+1)'(Q_DEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    fw_ext = CMP_W'(frame_width);
    if (fw_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    c_inc = CMP_W'(col_pos_r) + CMP_W'(1);
    last  = (c_inc >= w_eff);

    col_pos_nxt = col_pos_r;
    rows_nxt    = rows_r;
    if (accept) begin
      if (last) begin
        col_pos_nxt = '0;
        if (in_data.kind) begin
          rows_nxt = 2'd0;
        end else if (rows_r < 2'd2) begin
          rows_nxt = rows_r + 2'd1;
        end
      end else begin
        col_pos_nxt = c_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      rows_r    <= '0;
      s2_v_r    <= 1'b0;
    end else begin
      col_pos_r <= col_pos_nxt;
      rows_r    <= rows_nxt;
      s2_v_r    <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_kind_r  <= in_data.kind;
      s2_pix_r   <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      s2_c_r     <= col_pos_r;
      s2_last_r  <= last;
      s2_rows_r  <= rows_r;
      // the word in stage two writes this very entry on the same edge
      byp_v_r    <= s2_v_r && (s2_c_r == col_pos_r);
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[col_pos_r];
    end
    if (s2_v_r) begin
      mem[s2_c_r] <= wr_data;
    end
  end

  always_comb begin
    rows_word = byp_v_r ? byp_data_r : rd_data_r;
    top       = rows_word[2*RGB_W-1:RGB_W];
    centre    = rows_word[RGB_W-1:0];
    wr_data   = {centre, s2_kind_r ? {RGB_W{1'b0}} : s2_pix_r};

    for (int k = 0; k < 3; k++) begin
      push_data.col[k] = ((s2_rows_r >= 2'd2) ? CSUM_W'(top[PIX_W*k +: PIX_W]) : '0)
                       + ((s2_rows_r >= 2'd1) ? CSUM_W'(centre[PIX_W*k +: PIX_W]) : '0)
                       + (!s2_kind_r ? CSUM_W'(s2_pix_r[PIX_W*k +: PIX_W]) : '0);
    end
    push_data.vcnt  = 2'd1 + 2'((s2_rows_r >= 2'd2)) + 2'(!s2_kind_r);
    push_data.c_ge1 = (s2_c_r >= COL_W'(1));
    push_data.c_ge2 = (s2_c_r >= COL_W'(2));
    push_data.last  = s2_last_r;
    push_data.kind  = s2_kind_r;
    push_data.rs1   = (s2_rows_r >= 2'd1);
  end

  assign push = s2_v_r;

endmodule

[rtl/core/bbl_back.sv]
// ----------------------------------------------------------------------------
// bbl_back
// Keeps the two previous column sums, forms up to two results per word and
// divides them into rounded means.
// ----------------------------------------------------------------------------
module bbl_back
  import bbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  bbl_qstat_t qstat,
  output logic       pop,
  input  bbl_entry_t pop_data,
  output logic       out_valid,
  input  logic       out_stall,
  output bbl_out_t   out_data
);

  // (2s + d) / (2d), rounded half up, capped; thirds and ninths by reciprocal
  function automatic logic [PIX_W-1:0] div_round(input logic [SUM_W-1:0] s,
                                                 input logic [DIV_W-1:0] d);
    logic [SUM_W+1:0] x;
    logic [SUM_W-1:0] y;
    logic [SUM_W-1:0] q;
    logic [2*SUM_W-1:0] prod;
    x    = {s, 1'b0} + (SUM_W+2)'(d);
    y    = '0;
    prod = '0;
    case (d)
      4'd1: q = SUM_W'(x >> 1);
      4'd2: q = SUM_W'(x >> 2);
      4'd4: q = SUM_W'(x >> 3);
      4'd3: begin
        y    = SUM_W'(x >> 1);
        prod = (2*SUM_W)'(y) * (2*SUM_W)'(2731);
        q    = SUM_W'(prod >> 13);
      end
      4'd6: begin
        y    = SUM_W'(x >> 2);
        prod = (2*SUM_W)'(y) * (2*SUM_W)'(2731);
        q    = SUM_W'(prod >> 13);
      end
      4'd9: begin
        y    = SUM_W'(x >> 1);
        prod = (2*SUM_W)'(y) * (2*SUM_W)'(3641);
        q    = SUM_W'(prod >> 15);
      end
      default: q = SUM_W'(x >> 1);
    endcase
    return (q > SUM_W'(255)) ? PIX_W'(255) : q[PIX_W-1:0];
  endfunction

  bbl_entry_t             w_r;
  logic                   wv_r;
  logic                   phase_r;
  logic [2:0][CSUM_W-1:0] left_r, mid_r;

  logic                   sum_v_r;
  logic [2:0][SUM_W-1:0]  sum_r;
  logic [DIV_W-1:0]       div_r;
  logic                   rl_r, fe_r;

  bbl_out_t               out_data_r;
  logic                   out_valid_r;

  logic                   need_a, need_b, sel_a, has_res, final_res;
  logic                   out_ld, sum_rdy, emit, retire;
  logic [2:0][SUM_W-1:0]  sums;
  logic [DIV_W-1:0]       div_sel;
  logic [1:0]             hcnt;

  always_comb begin
    need_a    = w_r.rs1 && w_r.c_ge1;
    need_b    = w_r.rs1 && w_r.last;
    sel_a     = !phase_r && need_a;
    has_res   = sel_a || need_b;
    final_res = !(sel_a && need_b);

    out_ld  = sum_v_r && (!out_valid_r || !out_stall);
    sum_rdy = !sum_v_r || out_ld;
    emit    = wv_r && has_res && sum_rdy;
    retire  = wv_r && (!has_res || (emit && final_res));
    pop     = !qstat.empty && (!wv_r || retire);

    for (int k = 0; k < 3; k++) begin
      if (sel_a) begin
        sums[k] = (w_r.c_ge2 ? SUM_W'(left_r[k]) : '0) + SUM_W'(mid_r[k])
                + SUM_W'(w_r.col[k]);
      end else begin
        sums[k] = (w_r.c_ge1 ? SUM_W'(mid_r[k]) : '0) + SUM_W'(w_r.col[k]);
      end
    end
    if (sel_a) begin
      hcnt = w_r.c_ge2 ? 2'd3 : 2'd2;
    end else begin
      hcnt = w_r.c_ge1 ? 2'd2 : 2'd1;
    end
    div_sel = DIV_W'(w_r.vcnt) * DIV_W'(hcnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r        <= 1'b0;
      phase_r     <= 1'b0;
      left_r      <= '0;
      mid_r       <= '0;
      sum_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        wv_r    <= 1'b1;
        phase_r <= 1'b0;
      end else if (retire) begin
        wv_r    <= 1'b0;
      end else if (emit) begin
        phase_r <= 1'b1;
      end
      if (retire) begin
        left_r <= w_r.c_ge1 ? mid_r : '0;
        mid_r  <= w_r.col;
      end
      sum_v_r     <= emit || (sum_v_r && !out_ld);
      out_valid_r <= out_ld || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_r <= pop_data;
    end
    if (emit) begin
      sum_r <= sums;
      div_r <= div_sel;
      rl_r  <= final_res;
      fe_r  <= !sel_a && w_r.kind;
    end
    if (out_ld) begin
      out_data_r.red_out   <= div_round(sum_r[2], div_r);
      out_data_r.green_out <= div_round(sum_r[1], div_r);
      out_data_r.blue_out  <= div_round(sum_r[0], div_r);
      out_data_r.run_last  <= rl_r;
      out_data_r.frame_end <= fe_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/box_blur_three_by_three_top.sv]
// ----------------------------------------------------------------------------
// box_blur_three_by_three_top
// 3x3 box blur over an RGB raster stream, edge-aware divisor, rounded means.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall  | kind, red/green/blue pixel
//   out_    | output    | out_valid/out_stall| blurred pixel, run_last, frame_end
//   cfg_    | input     | APB write/read     | frame_width at byte address 0
//
// Front takes one word a cycle while in_stall is low; its line-store read is
// registered. Back gives one result a cycle unless the output stalls, so a row's
// last word (up to two results) holds it until both are out; a four-word queue
// lets front and back stall separately.
// No clearing pass after reset: the line stores are undefined until written.
// ----------------------------------------------------------------------------
module box_blur_three_by_three_top
  import bbl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bbl_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bbl_out_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [FW_W-1:0] fw_r;
  logic            reg_hit;
  logic            push, pop;
  bbl_entry_t      push_data, pop_data;
  bbl_qstat_t      qstat;

  assign reg_hit    = (cfg_paddr[ADDR_W-1:2] == REG_FRAME_WIDTH);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? DATA_W'(fw_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      fw_r <= cfg_pwdata[FW_W-1:0];
    end
  end

  bbl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .frame_width (fw_r),
    .qstat       (qstat),
    .push        (push),
    .push_data   (push_data)
  );

  bbl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (qstat)
  );

  bbl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/bbl_checker.sv]
// ----------------------------------------------------------------------------
// bbl_checker
// Port-level checks on the box blur, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_blur_three_by_three_top_assert.svh"

module bbl_checker
  import bbl_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input bbl_in_t           in_data,
  input logic              out_valid,
  input logic              out_stall,
  input bbl_out_t          out_data,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [ADDR_W-1:0] cfg_paddr,
  input logic [DATA_W-1:0] cfg_pwdata,
  input logic [DATA_W-1:0] cfg_prdata,
  input logic              cfg_pready
);

  // a stalled result word stays put
  `BBL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "out word changed under stall")

  // frame end only ever closes the run of a row's last word
  `BBL_ASSERT_SAME(a_fe_last, clk, rst_n, out_valid && out_data.frame_end, out_data.run_last, "frame_end without run_last")

  // nothing comes out straight after reset
  `BBL_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n, !out_valid, "out_valid after reset")

  `BBL_ASSERT_SAME(a_pready, clk, rst_n, cfg_psel, cfg_pready, "pready low")

endmodule

bind box_blur_three_by_three_top bbl_checker u_bbl_checker (.*);

[tb/box_blur_three_by_three_top_tb.sv]
// ----------------------------------------------------------------------------
// box_blur_three_by_three_top_tb
// Self-checking bench for the 3x3 box blur. An in-bench line-store predictor
// works out the blurred words for every accepted pixel word. A short directed
// run covers edge divisors, flush rows, capped means and odd widths. Random
// frames follow, mostly well formed, some with mixed or unclosed rows. Both
// channels idle and stall at random. frame_width is rewritten between frames
// and narrowed mid-row.
// ----------------------------------------------------------------------------
module box_blur_three_by_three_top_tb;
  import bbl_pkg::*;

  localparam int IDLE_PCT      = 7;
  localparam int SETTLE_CYCLES = 12;
  localparam int RAND_WORDS    = 610;

  localparam bit KIND_PIXEL = 1'b0;
  localparam bit KIND_FLUSH = 1'b1;

  typedef enum logic [1:0] {ROW_IMAGE, ROW_FLUSH, ROW_NOISE} row_kind_e;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  bbl_in_t           in_data     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  bbl_out_t          out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  box_blur_three_by_three_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // predictor state
  bit [RGB_W-1:0]  line_older [MAX_WIDTH];
  bit [RGB_W-1:0]  line_newer [MAX_WIDTH];
  int unsigned     col_pos;
  int unsigned     rows_held;
  int unsigned     left_sums [3];
  int unsigned     mid_sums [3];
  logic [FW_W-1:0] width_reg = FW_RESET;

  bbl_in_t     pixel_words [$];
  bbl_out_t    blurred_expected [$];
  int unsigned error_count;
  int unsigned words_queued;
  int unsigned words_shown;
  int unsigned words_taken;
  bit          calm;
  bit          hold_sender;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_width(logic [FW_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] rounded_mean(int unsigned s, int unsigned d);
    int unsigned q;
    q = (2 * s + d) / (2 * d);
    return (q > 255) ? 8'd255 : q[PIX_W-1:0];
  endfunction

  function automatic bbl_out_t blurred_pixel(int unsigned sums [3], int unsigned div);
    bbl_out_t r;
    r.red_out   = rounded_mean(sums[2], div);
    r.green_out = rounded_mean(sums[1], div);
    r.blue_out  = rounded_mean(sums[0], div);
    r.run_last  = 1'b0;
    r.frame_end = 1'b0;
    return r;
  endfunction

  // channel index 0 blue, 1 green, 2 red, as packed in the line stores
  task automatic blur_predict(input bbl_in_t w_in);
    int unsigned w, c, vcnt, n;
    int unsigned pix [3];
    int unsigned colsum [3];
    int unsigned acc [3];
    bit          row_end;
    bbl_out_t    res [2];
    w = eff_width(width_reg);
    c = (col_pos >= MAX_WIDTH) ? 0 : col_pos;
    row_end = (c + 1 >= w);
    pix[0] = w_in.blue_in;
    pix[1] = w_in.green_in;
    pix[2] = w_in.red_in;
    for (int k = 0; k < 3; k++) begin
      colsum[k] = 0;
      if (rows_held >= 2) colsum[k] += line_older[c][8*k +: 8];
      if (rows_held >= 1) colsum[k] += line_newer[c][8*k +: 8];
      if (w_in.kind == KIND_PIXEL) colsum[k] += pix[k];
    end
    // vertical part of the divisor follows the word that causes the result
    vcnt = (rows_held >= 2 ? 1 : 0) + 1 + (w_in.kind == KIND_PIXEL ? 1 : 0);
    n = 0;
    if (rows_held >= 1) begin
      if (c >= 1) begin
        for (int k = 0; k < 3; k++)
          acc[k] = (c >= 2 ? left_sums[k] : 0) + mid_sums[k] + colsum[k];
        res[n] = blurred_pixel(acc, vcnt * (c >= 2 ? 3 : 2));
        n++;
      end
      if (row_end) begin
        for (int k = 0; k < 3; k++)
          acc[k] = (c >= 1 ? mid_sums[k] : 0) + colsum[k];
        res[n] = blurred_pixel(acc, vcnt * (c >= 1 ? 2 : 1));
        n++;
      end
      if (n > 0) begin
        res[n-1].run_last  = 1'b1;
        res[n-1].frame_end = row_end && (w_in.kind == KIND_FLUSH);
      end
      for (int i = 0; i < n; i++) blurred_expected.push_back(res[i]);
    end
    line_older[c] = line_newer[c];
    line_newer[c] = (w_in.kind == KIND_FLUSH) ? '0 :
                    {w_in.red_in, w_in.green_in, w_in.blue_in};
    for (int k = 0; k < 3; k++) begin
      left_sums[k] = (c >= 1) ? mid_sums[k] : 0;
      mid_sums[k]  = colsum[k];
    end
    if (row_end) begin
      col_pos = 0;
      if (w_in.kind == KIND_FLUSH) rows_held = 0;
      else if (rows_held < 2) rows_held++;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : blur_monitor
    bbl_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (blurred_expected.size() == 0) begin
          report_mismatch("blurred word with none pending, red_out", out_data.red_out, 0);
        end else begin
          want = blurred_expected.pop_front();
          if (out_data.red_out !== want.red_out)
            report_mismatch("red_out", out_data.red_out, want.red_out);
          if (out_data.green_out !== want.green_out)
            report_mismatch("green_out", out_data.green_out, want.green_out);
          if (out_data.blue_out !== want.blue_out)
            report_mismatch("blue_out", out_data.blue_out, want.blue_out);
          if (out_data.run_last !== want.run_last)
            report_mismatch("run_last", out_data.run_last, want.run_last);
          if (out_data.frame_end !== want.frame_end)
            report_mismatch("frame_end", out_data.frame_end, want.frame_end);
        end
      end
      if (in_valid && !in_stall) begin
        blur_predict(in_data);
        words_taken++;
      end
    end
  end

  // a shown word stays put until taken
  always @(negedge clk) begin : word_driver
    if (!in_valid || words_taken == words_shown) begin
      if (rst_n && !hold_sender && pixel_words.size() != 0 &&
          (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= pixel_words.pop_front();
        words_shown++;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !calm && ($urandom_range(99, 0) < IDLE_PCT);
  end

  function automatic logic [PIX_W-1:0] pick_level();
    logic [PIX_W-1:0] v;
    case ($urandom_range(7, 0))
      0:       v = 8'd255;
      1:       v = 8'd0;
      default: v = $urandom_range(255, 0);
    endcase
    return v;
  endfunction

  task automatic queue_word(input bit kind, input logic [PIX_W-1:0] r,
                            input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    bbl_in_t w;
    w.kind     = kind;
    w.red_in   = r;
    w.green_in = g;
    w.blue_in  = b;
    pixel_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_row(input int unsigned n, input row_kind_e how);
    bit kind;
    for (int unsigned i = 0; i < n; i++) begin
      case (how)
        ROW_IMAGE: kind = KIND_PIXEL;
        ROW_FLUSH: kind = KIND_FLUSH;
        default:   kind = ($urandom_range(3, 0) == 0) ? KIND_FLUSH : KIND_PIXEL;
      endcase
      queue_word(kind, pick_level(), pick_level(), pick_level());
    end
  endtask

  task automatic settle();
    while (pixel_words.size() != 0 || in_valid) @(posedge clk);
    while (blurred_expected.size() != 0) @(posedge clk);
    // words with no result may still be in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    hold_sender = 1'b1;
    while (in_valid) @(posedge clk);
    while (blurred_expected.size() != 0) @(posedge clk);
    hold_sender = 1'b0;
  endtask

  task automatic write_width(input logic [FW_W-1:0] v);
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] back;
    wdata = $urandom();
    wdata[FW_W-1:0] = v;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_FRAME_WIDTH, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    width_reg = v;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    back = cfg_prdata;
    if (back[FW_W-1:0] !== v) report_mismatch("frame_width readback", back[FW_W-1:0], v);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic change_width(input logic [FW_W-1:0] want);
    logic [FW_W-1:0] v;
    v = want;
    settle();
    // an open frame may only narrow: wider rows would read unwritten line entries
    if (rows_held != 0 && eff_width(v) > eff_width(width_reg))
      v = $urandom_range(eff_width(width_reg), 1);
    write_width(v);
  endtask

  initial begin : stimulus
    int unsigned directed_words, frame_no, w, n_rows, style, part, rest;
    logic [FW_W-1:0] cand;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset width, then narrowed under the column: next word closes row 0
    queue_word(KIND_PIXEL, 8'd255, 8'd0, 8'd255);
    queue_word(KIND_PIXEL, 8'd0, 8'd255, 8'd0);
    change_width(11'd2);
    queue_word(KIND_PIXEL, 8'd18, 8'd52, 8'd86);
    queue_row(2, ROW_IMAGE);
    queue_row(2, ROW_FLUSH);

    // full 3x3 frame closed by a mixed row; the means there saturate
    change_width(11'd3);
    queue_word(KIND_PIXEL, 8'd0, 8'd0, 8'd0);
    queue_word(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    queue_word(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    repeat (3) queue_word(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    repeat (2) queue_word(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    queue_word(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    // flush row with nothing held: silent
    queue_row(3, ROW_FLUSH);

    change_width(11'd1);
    queue_word(KIND_FLUSH, 8'd255, 8'd255, 8'd255);
    queue_word(KIND_PIXEL, 8'd255, 8'd255, 8'd255);
    queue_word(KIND_PIXEL, 8'd0, 8'd0, 8'd0);
    queue_word(KIND_FLUSH, 8'd0, 8'd0, 8'd0);

    change_width(11'd0);
    queue_word(KIND_PIXEL, 8'd200, 8'd100, 8'd50);
    queue_word(KIND_FLUSH, 8'd0, 8'd0, 8'd0);
    directed_words = words_queued;

    frame_no = 0;
    while (words_queued < directed_words + RAND_WORDS) begin
      frame_no++;
      calm = (frame_no >= 10 && frame_no < 18);
      if (frame_no == 1 || $urandom_range(2, 0) == 0) begin
        case ($urandom_range(11, 0))
          0:       cand = 11'd0;
          1:       cand = 11'd1;
          2:       cand = $urandom_range(40, 10);
          default: cand = $urandom_range(9, 1);
        endcase
        change_width(cand);
      end
      w = eff_width(width_reg);
      n_rows = $urandom_range(4, 0);
      style = $urandom_range(9, 0);
      if (style < 7) begin
        for (int unsigned r = 0; r < n_rows; r++) begin
          if (r == 1 && w >= 2 && $urandom_range(3, 0) == 0) begin
            // narrow mid-row; the column may already lie past the new end
            part = $urandom_range(w - 1, 1);
            queue_row(part, ROW_IMAGE);
            change_width($urandom_range(w, 1));
            w = eff_width(width_reg);
            rest = (col_pos + 1 >= w) ? 1 : w - col_pos;
            queue_row(rest, ROW_IMAGE);
          end else begin
            queue_row(w, ROW_IMAGE);
          end
        end
        queue_row(w, ROW_FLUSH);
      end else begin
        for (int unsigned r = 0; r < n_rows; r++) queue_row(w, ROW_NOISE);
        // otherwise the frame is left open
        if (style < 9) queue_row(w, ROW_FLUSH);
      end
      if ($urandom_range(7, 0) == 0) hold_until_drained();
    end
    calm = 1'b0;

    // over-range width: close any open frame first so widening is legal
    settle();
    if (rows_held != 0) begin
      queue_row(eff_width(width_reg), ROW_FLUSH);
      settle();
    end
    write_width(11'd2047);
    queue_row(5, ROW_IMAGE);
    // narrowed behind the column: the next word closes the row
    change_width(11'd3);
    queue_row(1, ROW_IMAGE);
    queue_row(3, ROW_FLUSH);

    while (pixel_words.size() != 0 || in_valid) @(posedge clk);
    for (int i = 0; i < 4000 && blurred_expected.size() != 0; i++) @(posedge clk);
    if (blurred_expected.size() != 0)
      report_mismatch("blurred words never delivered", blurred_expected.size(), 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("box_blur_three_by_three_top_tb: done, clean");
    end else begin
      $display("box_blur_three_by_three_top_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("box_blur_three_by_three_top_tb: done, errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bbl_pkg.sv
rtl/core/bbl_queue.sv
rtl/core/bbl_front.sv
rtl/core/bbl_back.sv
rtl/core/box_blur_three_by_three_top.sv
rtl/core/bbl_checker.sv
tb/box_blur_three_by_three_top_tb.sv
